### hdl/hpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_pkg
// Shared types and codes of the half-plane rectangle query core.
// ----------------------------------------------------------------------------
package hpr_pkg;

    localparam int BoundW = 40;
    localparam int CoefW  = 24;
    localparam int DiffW  = BoundW + 1;
    localparam int AreaW  = 64;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DEGEN     = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [CoefW-1:0]  coef_a;
        logic signed [CoefW-1:0]  coef_b;
        logic signed [CoefW-1:0]  coef_c;
        logic signed [BoundW-1:0] point_x;
        logic signed [BoundW-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [AreaW-1:0] area;
    } t_out_item;

    typedef struct packed {
        logic signed [BoundW-1:0] bound;
        logic                     vertical;
        logic                     positive;
    } t_plane;

    typedef struct packed {
        logic clr;
        logic en;
    } t_scan_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_EVAL,
        S_MUL,
        S_RESP
    } t_state;

endpackage

### hdl/hpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_cell
// One table slot: holds a plane and passes it to its neighbor on a shift.
// ----------------------------------------------------------------------------
module hpr_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  hpr_pkg::t_plane i_plane,
    output hpr_pkg::t_plane o_plane
);
    import hpr_pkg::*;

    t_plane r_plane;

    // take the neighbor's plane on a shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_plane <= i_plane;
        end
    end

    assign o_plane = r_plane;
endmodule

### hdl/hpr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_div
// Bit-serial bound divider: trunc(-c * 2^16 / d), saturated to 40 bits.
// ----------------------------------------------------------------------------
module hpr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hpr_pkg::CoefW-1:0]  i_c,
    input  logic signed [hpr_pkg::CoefW-1:0]  i_d,
    output logic                              o_done,
    output logic signed [hpr_pkg::BoundW-1:0] o_quot
);
    import hpr_pkg::*;

    localparam int StepW = $clog2(BoundW);

    logic              r_busy;
    logic [StepW-1:0]  r_step;
    logic [BoundW-1:0] r_dvd;
    logic [CoefW-1:0]  r_rem;
    logic [CoefW-1:0]  r_dsr;
    logic              r_neg;
    logic              r_done;

    logic [CoefW-1:0]  c_mag;
    logic [CoefW-1:0]  d_mag;
    logic [CoefW:0]    rem_sh;
    logic              ge;
    logic [CoefW:0]    rem_sub;

    assign c_mag   = i_c[CoefW-1] ? (~i_c + 1'b1) : i_c;
    assign d_mag   = i_d[CoefW-1] ? (~i_d + 1'b1) : i_d;
    assign rem_sh  = {r_rem, r_dvd[BoundW-1]};
    assign ge      = rem_sh >= {1'b0, r_dsr};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    // control: run one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == StepW'(BoundW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: restoring shift-subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {c_mag[BoundW-17:0], 16'd0};
            r_rem <= '0;
            r_dsr <= d_mag;
            r_neg <= (i_c > 0) ^ i_d[CoefW-1];
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[CoefW-1:0] : rem_sh[CoefW-1:0];
            r_dvd <= {r_dvd[BoundW-2:0], ge};
        end
    end

    // apply sign and saturate the positive end
    always_comb begin
        if (r_neg) begin
            o_quot = ~r_dvd + 1'b1;
        end else if (r_dvd[BoundW-1]) begin
            o_quot = {1'b0, {(BoundW-1){1'b1}}};
        end else begin
            o_quot = r_dvd;
        end
    end

    assign o_done = r_done;
endmodule

### hdl/hpr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_mul
// Shift-add area multiplier: (dy * dx) >> 16, saturated to 64 bits.
// ----------------------------------------------------------------------------
module hpr_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hpr_pkg::DiffW-1:0]      i_a,
    input  logic [hpr_pkg::DiffW-1:0]      i_b,
    output logic                           o_done,
    output logic [hpr_pkg::AreaW-1:0]      o_area
);
    import hpr_pkg::*;

    localparam int ProdW = 2 * DiffW;
    localparam int StepW = $clog2(DiffW);

    logic              r_busy;
    logic              r_done;
    logic [StepW-1:0]  r_step;
    logic [DiffW-1:0]  r_a;
    logic [ProdW-1:0]  r_p;
    logic [DiffW:0]    sum;

    assign sum = {1'b0, r_p[ProdW-1:DiffW]} + (r_p[0] ? {1'b0, r_a} : '0);

    // control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == StepW'(DiffW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: add and shift the partial product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{DiffW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {sum, r_p[DiffW-1:1]};
        end
    end

    // drop 16 fraction bits and clamp
    assign o_area = (|r_p[ProdW-1:AreaW+16]) ? {AreaW{1'b1}} : r_p[AreaW+15:16];
    assign o_done = r_done;
endmodule

### hdl/hpr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpr_scan
// Query accumulator: keeps the tightest bound on each side of the point.
// ----------------------------------------------------------------------------
module hpr_scan (
    input  logic                              i_clk,
    input  hpr_pkg::t_scan_ctl                i_ctl,
    input  hpr_pkg::t_plane                   i_plane,
    input  logic signed [hpr_pkg::BoundW-1:0] i_px,
    input  logic signed [hpr_pkg::BoundW-1:0] i_py,
    output logic                              o_found,
    output logic [hpr_pkg::DiffW-1:0]         o_dy,
    output logic [hpr_pkg::DiffW-1:0]         o_dx
);
    import hpr_pkg::*;

    logic signed [BoundW-1:0] r_px, r_py;
    logic signed [BoundW-1:0] r_xu, r_xl, r_yu, r_yl;
    logic                     r_hxu, r_hxl, r_hyu, r_hyl;

    logic signed [BoundW-1:0] v, pt;
    logic                     up_hit, lo_hit;
    logic signed [DiffW-1:0]  dy_s, dx_s;

    assign v  = i_plane.bound;
    assign pt = i_plane.vertical ? r_px : r_py;

    // candidate tests against the current side best
    always_comb begin
        up_hit = 1'b0;
        lo_hit = 1'b0;
        if (i_plane.positive) begin
            if (i_plane.vertical) begin
                up_hit = (v > pt) && (!r_hxu || r_xu > v);
            end else begin
                up_hit = (v > pt) && (!r_hyu || r_yu > v);
            end
        end else begin
            if (i_plane.vertical) begin
                lo_hit = (v < pt) && (!r_hxl || r_xl < v);
            end else begin
                lo_hit = (v < pt) && (!r_hyl || r_yl < v);
            end
        end
    end

    // reset on a new query, update on each valid entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_px  <= i_px;
            r_py  <= i_py;
            r_hxu <= 1'b0;
            r_hxl <= 1'b0;
            r_hyu <= 1'b0;
            r_hyl <= 1'b0;
        end else if (i_ctl.en) begin
            if (up_hit && i_plane.vertical) begin
                r_hxu <= 1'b1;
                r_xu  <= v;
            end
            if (up_hit && !i_plane.vertical) begin
                r_hyu <= 1'b1;
                r_yu  <= v;
            end
            if (lo_hit && i_plane.vertical) begin
                r_hxl <= 1'b1;
                r_xl  <= v;
            end
            if (lo_hit && !i_plane.vertical) begin
                r_hyl <= 1'b1;
                r_yl  <= v;
            end
        end
    end

    // rectangle sides as magnitudes
    assign dy_s    = DiffW'(r_yu) - DiffW'(r_yl);
    assign dx_s    = DiffW'(r_xu) - DiffW'(r_xl);
    assign o_dy    = dy_s[DiffW-1] ? DiffW'(-dy_s) : DiffW'(dy_s);
    assign o_dx    = dx_s[DiffW-1] ? DiffW'(-dx_s) : DiffW'(dx_s);
    assign o_found = r_hxu && r_hxl && r_hyu && r_hyl;
endmodule

### hdl/halfplane_enclosing_rectangle_query_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfplane_enclosing_rectangle_query_core
// Half-plane table with enclosing-rectangle query over a ring of slot cells.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  input    | i_valid | o_stall | i_item (hpr_pkg::t_in_item)
//  output   | o_valid | i_stall | o_item (hpr_pkg::t_out_item)
//
// One transaction at a time. Add: bit-serial division, then the plane
// enters the ring. Query: the ring rotates once past the accumulator,
// an evaluation follows, then a shift-add multiply when all sides exist.
// Clear and dropped adds respond directly. Reset empties the table at once.
// A stalled result holds the core until the output register frees.
// ----------------------------------------------------------------------------
module halfplane_enclosing_rectangle_query_core #(
    parameter int MAX_PLANES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hpr_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output hpr_pkg::t_out_item o_item
);
    import hpr_pkg::*;

    localparam int CntW  = $clog2(MAX_PLANES + 1);
    localparam int StepW = $clog2(MAX_PLANES);

    t_state            r_state, n_state;
    logic [CntW-1:0]   r_count;
    logic [StepW-1:0]  r_step;
    t_out_item         r_res;
    logic              r_oval;
    t_out_item         r_out;
    logic              r_vert, r_pos;

    logic       acc, degen, full, load, last_step, entry_ok;
    logic       div_start, div_done, mul_start, mul_done, shift;
    t_scan_ctl  scan_ctl;
    t_plane     new_plane, head_in;
    t_plane     cells [MAX_PLANES];
    logic signed [BoundW-1:0] quot;
    logic       found;
    logic [DiffW-1:0] dy, dx;
    logic [AreaW-1:0] area;
    logic signed [CoefW-1:0] dsel;

    assign acc       = i_valid && (r_state == S_IDLE);
    assign degen     = (i_item.coef_a == '0) && (i_item.coef_b == '0);
    assign full      = r_count == CntW'(MAX_PLANES);
    assign load      = (r_state == S_RESP) && (!r_oval || !i_stall);
    assign last_step = r_step == StepW'(MAX_PLANES - 1);
    assign entry_ok  = CntW'(r_step) >= (CntW'(MAX_PLANES) - r_count);
    assign dsel      = (i_item.coef_a == '0) ? i_item.coef_b : i_item.coef_a;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_item.operation)
                        OP_ADD:   n_state = (degen || full) ? S_RESP : S_DIV;
                        OP_QUERY: n_state = S_SCAN;
                        OP_CLEAR: n_state = S_RESP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV:  n_state = div_done ? S_RESP : S_DIV;
            S_SCAN: n_state = last_step ? S_EVAL : S_SCAN;
            S_EVAL: n_state = found ? S_MUL : S_RESP;
            S_MUL:  n_state = mul_done ? S_RESP : S_MUL;
            S_RESP: n_state = load ? S_IDLE : S_RESP;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall      = r_state != S_IDLE;
        div_start    = acc && (i_item.operation == OP_ADD) && !degen && !full;
        mul_start    = (r_state == S_EVAL) && found;
        scan_ctl.clr = acc && (i_item.operation == OP_QUERY);
        scan_ctl.en  = (r_state == S_SCAN) && entry_ok;
        shift        = div_done || (r_state == S_SCAN);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc && i_item.operation == OP_CLEAR) begin
                r_count <= '0;
            end else if (div_done) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_SCAN) begin
                r_step <= last_step ? '0 : r_step + 1'b1;
            end
            if (load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    // result and pending plane attributes
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_vert       <= i_item.coef_a != '0;
            r_pos        <= dsel > 0;
            r_res.area   <= '0;
            r_res.status <= (i_item.operation == OP_CLEAR) ? ST_CLEARED :
                            degen ? ST_DEGEN : ST_FULL;
        end
        if (div_done) begin
            r_res.status <= ST_STORED;
        end
        if (r_state == S_EVAL && !found) begin
            r_res.status <= ST_NOT_FOUND;
        end
        if (mul_done) begin
            r_res.status <= ST_FOUND;
            r_res.area   <= area;
        end
        if (load) begin
            r_out <= r_res;
        end
    end

    hpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_c     (i_item.coef_c),
        .i_d     (dsel),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign new_plane.bound    = quot;
    assign new_plane.vertical = r_vert;
    assign new_plane.positive = r_pos;

    // cell ring: new planes enter at the head, a query rotates the ring
    assign head_in = (r_state == S_SCAN) ? cells[MAX_PLANES-1] : new_plane;

    for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
        hpr_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_plane ((g == 0) ? head_in : cells[(g == 0) ? 0 : g - 1]),
            .o_plane (cells[g])
        );
    end

    hpr_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_plane (cells[MAX_PLANES-1]),
        .i_px    (i_item.point_x),
        .i_py    (i_item.point_y),
        .o_found (found),
        .o_dy    (dy),
        .o_dx    (dx)
    );

    hpr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (dy),
        .i_b     (dx),
        .o_done  (mul_done),
        .o_area  (area)
    );

    assign o_valid = r_oval;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_PLANES))
        else $error("plane count beyond table depth");
    a_not_found_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ST_NOT_FOUND |-> o_item.area == '0)
        else $error("area set without a rectangle");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_SCAN |-> r_step == '0)
        else $error("scan step left running");
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_count < CntW'(MAX_PLANES))
        else $error("store into a full table");
`endif
endmodule
